// ===== hdl/lrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Line ring buffer package
// Shared types, sizes and codes for the line ring buffer.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W        = 11;
  localparam int FREE_W       = 11;
  localparam int BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_STORED      = 3'd0,
    ST_REJECTED    = 3'd1,
    ST_LINE_BYTE   = 3'd2,
    ST_END_OF_LINE = 3'd3,
    ST_NO_LINE     = 3'd4
  } status_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] data_byte;
    logic              run_first;
    logic [LEN_W-1:0]  run_length;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] line_byte;
    logic [FREE_W-1:0] free_space;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== hdl/lrb_if.sv =====
// ----------------------------------------------------------------------------
// Line ring buffer channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface lrb_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        run_first;
  logic [10:0] run_length;

  modport source (output valid, action, data_byte, run_first, run_length, input ready);
  modport sink (input valid, action, data_byte, run_first, run_length, output ready);
endinterface

interface lrb_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  line_byte;
  logic [10:0] free_space;

  modport source (output valid, status, line_byte, free_space, input ready);
  modport sink (input valid, status, line_byte, free_space, output ready);
endinterface

// ===== hdl/lrb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/lrb_engine.sv =====
// ----------------------------------------------------------------------------
// Line ring buffer engine
// Pointer, wrap, newline and run state with the per-request update logic.
// ----------------------------------------------------------------------------
module lrb_engine
  import lrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  item_t             item,
  input  logic [BYTE_W-1:0] rd_data,
  output logic [PTR_W-1:0]  rd_addr,
  output mem_wr_t           mem_wr,
  output result_t           result
);

  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic              wrapped, wrapped_next;
  logic [CNT_W-1:0]  newline_count, newline_count_next;
  logic              run_rejected, run_rejected_next;
  logic              bypass_hit, bypass_hit_next;
  logic [BYTE_W-1:0] bypass_data;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  free_next;
  logic [BYTE_W-1:0] head_byte;
  status_t           status;
  logic [BYTE_W-1:0] line_byte;

  function automatic logic [CNT_W-1:0] space_of(logic [PTR_W-1:0] wp,
                                                logic [PTR_W-1:0] rp,
                                                logic             wr);
    logic [CNT_W-1:0] space;
    if (wr) begin
      space = (rp >= wp) ? (CNT_W'(rp) - CNT_W'(wp)) : '0;
    end else begin
      space = CNT_W'(BUFFER_DEPTH) - CNT_W'(wp) + CNT_W'(rp);
    end
    return space;
  endfunction

  always_comb begin
    room               = space_of(write_pointer, read_pointer, wrapped);
    head_byte          = bypass_hit ? bypass_data : rd_data;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    wrapped_next       = wrapped;
    newline_count_next = newline_count;
    run_rejected_next  = run_rejected;
    status             = ST_NO_LINE;
    line_byte          = '0;
    mem_wr.en          = 1'b0;
    mem_wr.addr        = write_pointer;
    mem_wr.data        = item.data_byte;
    if (advance) begin
      if (item.action == ACT_WRITE) begin
        if (item.run_first) begin
          run_rejected_next = (item.run_length > room) || (room == '0);
        end
        if (run_rejected_next || (room == '0)) begin
          status = ST_REJECTED;
        end else begin
          status    = ST_STORED;
          mem_wr.en = 1'b1;
          if (item.data_byte == NEWLINE_BYTE) begin
            newline_count_next = newline_count + CNT_W'(1);
          end
          if (write_pointer == PTR_W'(BUFFER_DEPTH - 1)) begin
            write_pointer_next = '0;
            wrapped_next       = 1'b1;
          end else begin
            write_pointer_next = write_pointer + PTR_W'(1);
          end
        end
      end else if (newline_count != '0) begin
        if (read_pointer == PTR_W'(BUFFER_DEPTH - 1)) begin
          read_pointer_next = '0;
          wrapped_next      = 1'b0;
        end else begin
          read_pointer_next = read_pointer + PTR_W'(1);
        end
        if (head_byte == NEWLINE_BYTE) begin
          newline_count_next = newline_count - CNT_W'(1);
          status             = ST_END_OF_LINE;
        end else begin
          status    = ST_LINE_BYTE;
          line_byte = head_byte;
        end
      end
    end
    free_next         = space_of(write_pointer_next, read_pointer_next, wrapped_next);
    rd_addr           = read_pointer_next;
    bypass_hit_next   = mem_wr.en && (mem_wr.addr == read_pointer_next);
    result.status     = status;
    result.line_byte  = line_byte;
    result.free_space = FREE_W'(free_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      wrapped       <= 1'b0;
      newline_count <= '0;
      run_rejected  <= 1'b0;
      bypass_hit    <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      wrapped       <= wrapped_next;
      newline_count <= newline_count_next;
      run_rejected  <= run_rejected_next;
      bypass_hit    <= bypass_hit_next;
    end
    bypass_data <= mem_wr.data;
  end

endmodule

// ===== hdl/line_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// Line ring buffer
// Circular byte store taking all-or-nothing write runs and giving back lines.
// ----------------------------------------------------------------------------
// Requests wait in the input register; results wait in the result register.
// Throughput: one request per cycle unless result.ready stalls the output.
// The byte store has one write and one registered read port; the read port
// prefetches the byte at the next read pointer.
// Reset is synchronous and clears pointers, counts and flags; the byte store
// is not cleared.
module line_ring_buffer_top
  import lrb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  lrb_item_if.sink     item,
  lrb_result_if.source result
);

  logic              s1_valid;
  item_t             s1_item;
  logic              advance;
  logic              out_valid;
  result_t           out_res;
  result_t           eng_res;
  mem_wr_t           mem_wr;
  logic [PTR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (item.valid && item.ready) || (s1_valid && !advance);
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (item.valid && item.ready) begin
      s1_item.action     <= item.action;
      s1_item.data_byte  <= item.data_byte;
      s1_item.run_first  <= item.run_first;
      s1_item.run_length <= item.run_length;
    end
    if (advance) begin
      out_res <= eng_res;
    end
  end

  lrb_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .mem_wr  (mem_wr),
    .result  (eng_res)
  );

  lrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign result.valid      = out_valid;
  assign result.status     = out_res.status;
  assign result.line_byte  = out_res.line_byte;
  assign result.free_space = out_res.free_space;

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> s1_valid)
    else $error("Accepted request did not reach the input register.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("Stalled request was lost or changed.");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.free_space <= FREE_W'(BUFFER_DEPTH))
    else $error("Free space exceeds the store depth.");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status != ST_LINE_BYTE) |-> out_res.line_byte == '0)
    else $error("Line byte is not zero outside a line byte result.");

endmodule
